>>> hw/rtl/counter_wait_slot_table_unit_macros.svh
// Assertion macros for the counter wait slot table checker.
// Used only by cwst_checker.sv; expects aclk and aresetn in scope.
`ifndef COUNTER_WAIT_SLOT_TABLE_UNIT_MACROS_SVH
`define COUNTER_WAIT_SLOT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CWST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cwst check failed");

// Next-cycle implication, checked outside reset
`define CWST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cwst check failed");

`endif

>>> hw/rtl/cwst_pkg.sv
// Shared types and codes for the counter wait slot table.
// No dependencies; imported by the top level and the checker.
package cwst_pkg;

    localparam int KIND_W   = 3;
    localparam int FIBER_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int THREAD_W = 7;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READY_ADD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE      = 3'd4;

    // One wait slot as stored in the slot memory
    typedef struct packed {
        logic [VALUE_W-1:0]  target;
        logic [FIBER_W-1:0]  waiter;
        logic [THREAD_W-1:0] thread;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

>>> hw/rtl/cwst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cwst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/counter_wait_slot_table_unit.sv
// Counter wait slot table: slot contents in one RAM, busy bits in flops.
// Add: the result register loads on the transfer; the next add may follow at once
// when the output is free. Update: one RAM read per busy slot, each compared with
// the new count, then a finish step that sends the last result; output stalls
// can hold the scan. One item is in work at a time.
// Reset clears busy bits, the count and all control state; no clearing pass.
module counter_wait_slot_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [cwst_pkg::FIBER_W-1:0]    s_fiber_id,
    input  logic [cwst_pkg::VALUE_W-1:0]    s_target_value,
    input  logic [cwst_pkg::THREAD_W-1:0]   s_pinned_thread,
    input  logic [cwst_pkg::VALUE_W-1:0]    s_new_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cwst_pkg::KIND_W-1:0]     m_kind,
    output logic [cwst_pkg::FIBER_W-1:0]    m_ready_fiber,
    output logic [cwst_pkg::THREAD_W-1:0]   m_ready_thread,
    output logic                            m_last
);

    import cwst_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t               state_reg, state_next;
    logic [SLOTS-1:0]     busy_reg, busy_next;
    logic [SLOTS-1:0]     pend_reg, pend_next;
    logic [VALUE_W-1:0]   count_reg, count_next;
    logic                 cmp_v_reg, cmp_v_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hold_v_reg, hold_v_next;
    logic [FIBER_W-1:0]   hold_fiber_reg, hold_fiber_next;
    logic [THREAD_W-1:0]  hold_thread_reg, hold_thread_next;
    logic                 m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [FIBER_W-1:0]   m_fiber_reg, m_fiber_next;
    logic [THREAD_W-1:0]  m_thread_reg, m_thread_next;
    logic                 m_last_reg, m_last_next;

    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     pend_idx;
    slot_entry_t          wr_entry;
    slot_entry_t          rd_entry;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 out_free;
    logic                 match;
    logic                 stall;

    // Slot memory: target, waiter and thread per slot
    cwst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (pend_idx),
        .rd_data (rd_data)
    );

    assign rd_entry = slot_entry_t'(rd_data);

    // Find the lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Find the lowest slot still to be scanned
    always_comb begin
        pend_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                pend_idx = IDX_W'(i);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign match    = cmp_v_reg && (rd_entry.target == count_reg);
    assign stall    = match && hold_v_reg && !out_free;

    assign wr_entry.target = s_target_value;
    assign wr_entry.waiter = s_fiber_id;
    assign wr_entry.thread = s_pinned_thread;

    // Next-state logic
    always_comb begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        pend_next        = pend_reg;
        count_next       = count_reg;
        cmp_v_next       = cmp_v_reg;
        cmp_idx_next     = cmp_idx_reg;
        hold_v_next      = hold_v_reg;
        hold_fiber_next  = hold_fiber_reg;
        hold_thread_next = hold_thread_reg;
        m_valid_next     = m_valid_reg;
        m_kind_next      = m_kind_reg;
        m_fiber_next     = m_fiber_reg;
        m_thread_next    = m_thread_reg;
        m_last_next      = m_last_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        // Drop the result once its transfer completes
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_command == CMD_ADD) begin
                        // Answer the add at once
                        m_valid_next  = 1'b1;
                        m_last_next   = 1'b1;
                        m_fiber_next  = '0;
                        m_thread_next = '0;
                        if (&busy_reg) begin
                            m_kind_next = KIND_FULL;
                        end else if (s_target_value == count_reg) begin
                            m_kind_next   = KIND_READY_ADD;
                            m_fiber_next  = s_fiber_id;
                            m_thread_next = s_pinned_thread;
                        end else begin
                            m_kind_next         = KIND_QUEUED;
                            wr_en               = 1'b1;
                            busy_next[free_idx] = 1'b1;
                        end
                    end else begin
                        // Store the count and scan every busy slot
                        count_next  = s_new_value;
                        pend_next   = busy_reg;
                        cmp_v_next  = 1'b0;
                        hold_v_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!cmp_v_reg && (pend_reg == '0)) begin
                    // Finish: flush the held release as last, or report none
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b1;
                        if (hold_v_reg) begin
                            m_kind_next   = KIND_RELEASED;
                            m_fiber_next  = hold_fiber_reg;
                            m_thread_next = hold_thread_reg;
                        end else begin
                            m_kind_next   = KIND_NONE;
                            m_fiber_next  = '0;
                            m_thread_next = '0;
                        end
                        hold_v_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    // Release a matching slot; the previous release goes out
                    if (match && !stall) begin
                        if (hold_v_reg) begin
                            m_valid_next  = 1'b1;
                            m_last_next   = 1'b0;
                            m_kind_next   = KIND_RELEASED;
                            m_fiber_next  = hold_fiber_reg;
                            m_thread_next = hold_thread_reg;
                        end
                        hold_v_next            = 1'b1;
                        hold_fiber_next        = rd_entry.waiter;
                        hold_thread_next       = rd_entry.thread;
                        busy_next[cmp_idx_reg] = 1'b0;
                    end
                    // Advance the read to the next busy slot
                    if (!stall) begin
                        if (pend_reg != '0) begin
                            rd_en               = 1'b1;
                            pend_next[pend_idx] = 1'b0;
                            cmp_idx_next        = pend_idx;
                            cmp_v_next          = 1'b1;
                        end else begin
                            cmp_v_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            pend_reg    <= '0;
            count_reg   <= '0;
            cmp_v_reg   <= 1'b0;
            hold_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            cmp_v_reg   <= cmp_v_next;
            hold_v_reg  <= hold_v_next;
            m_valid_reg <= m_valid_next;
        end
        cmp_idx_reg     <= cmp_idx_next;
        hold_fiber_reg  <= hold_fiber_next;
        hold_thread_reg <= hold_thread_next;
        m_kind_reg      <= m_kind_next;
        m_fiber_reg     <= m_fiber_next;
        m_thread_reg    <= m_thread_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_ready_fiber  = m_fiber_reg;
    assign m_ready_thread = m_thread_reg;
    assign m_last         = m_last_reg;

endmodule

>>> hw/rtl/cwst_checker.sv
// Port-level checks for counter_wait_slot_table_unit, bound to the top level.
// Depends on cwst_pkg and counter_wait_slot_table_unit_macros.svh.
`include "counter_wait_slot_table_unit_macros.svh"

module cwst_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [cwst_pkg::KIND_W-1:0]     m_kind,
    input logic [cwst_pkg::FIBER_W-1:0]    m_ready_fiber,
    input logic [cwst_pkg::THREAD_W-1:0]   m_ready_thread,
    input logic                            m_last
);

    import cwst_pkg::*;

    logic single_kind;

    // Kinds that always stand alone and carry no waiter
    assign single_kind = (m_kind == KIND_QUEUED) || (m_kind == KIND_FULL) ||
                         (m_kind == KIND_NONE);

    // Hold a stalled result
    `CWST_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_ready_fiber) && $stable(m_last))

    // Close every queued or full add and every empty update with last
    `CWST_ASSERT_NOW(a_single_last, m_valid && single_kind, m_last)

    // Zero the waiter fields where no waiter is released
    `CWST_ASSERT_NOW(a_single_zero, m_valid && single_kind, (m_ready_fiber == '0) && (m_ready_thread == '0))

    // Take no new item while a release run is still open
    `CWST_ASSERT_NOW(a_no_accept_mid_run, m_valid && !m_last, !s_ready)

    // Show a release kind on every result that is not last
    `CWST_ASSERT_NOW(a_mid_run_kind, m_valid && !m_last, m_kind == KIND_RELEASED)

endmodule

bind counter_wait_slot_table_unit cwst_checker u_cwst_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_ready_fiber  (m_ready_fiber),
    .m_ready_thread (m_ready_thread),
    .m_last         (m_last)
);
